// ===== design/gfpu_pkg.sv =====
// Shared constants and types for the gyro frame parser with angle unwrap.
package gfpu_pkg;

   typedef logic signed [15:0] word_type;
   typedef logic [7:0] byte_type;

   localparam byte_type HEADER_BYTE = 8'hAA;
   localparam int FIRST_STORED = 3;
   localparam int LAST_STORED = 12;
   localparam int STORED_BYTES = LAST_STORED - FIRST_STORED + 1;

   localparam logic signed [31:0] TURN_SPAN = 32'sd36000;
   localparam int MUL_BITS = 20;
   localparam logic [MUL_BITS-1:0] VEL_SCALE = 20'd1000000;
   localparam int PROD_WIDTH = 53;
   localparam int DIV_STEPS = PROD_WIDTH;

   localparam logic [1:0] CSR_WRAP_HIGH = 2'd0;
   localparam logic [1:0] CSR_WRAP_LOW = 2'd1;

   function automatic word_type neg_word(input byte_type lo, input byte_type hi);
      neg_word = word_type'(16'd0 - {hi, lo});
   endfunction

endpackage

// ===== design/gyro_frame_parser_unwrap_core.sv =====
// Gyro frame parser: byte framing, word unpack, turn count and velocity sequencer.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_rx_byte, req_arrival_time_us
//   rsp      out        rsp_valid / rsp_ready     rsp_raw_angle .. rsp_frame_count
//   csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// The first frame's last byte goes from the turn step straight to the result step;
// every later frame's last byte runs the turn, unwrap, delta and prepare steps, then
// 20 shift-add steps on the shared 54-bit adder for the scale by one million and 53
// restoring division steps, both skipped when the elapsed time is zero. Reset is
// synchronous and needs no clearing pass. A full result register holds the sequencer
// at its last step, and no byte is taken until the sequencer is back in idle.
module gyro_frame_parser_unwrap_core
   import gfpu_pkg::*;
#(
   parameter int FRAME_LENGTH = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic [31:0]         req_arrival_time_us,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_raw_angle,
   output logic signed [15:0]  rsp_raw_rate,
   output logic signed [15:0]  rsp_accel_x,
   output logic signed [15:0]  rsp_accel_y,
   output logic signed [15:0]  rsp_accel_z,
   output logic signed [31:0]  rsp_unwrapped_angle,
   output logic signed [31:0]  rsp_angular_velocity,
   output logic                rsp_first_frame,
   output logic [31:0]         rsp_frame_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   localparam logic [4:0] LAST_POS = 5'(FRAME_LENGTH - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TURN   = 3'd1;
   localparam logic [2:0] S_UNWRAP = 3'd2;
   localparam logic [2:0] S_DELTA  = 3'd3;
   localparam logic [2:0] S_PREP   = 3'd4;
   localparam logic [2:0] S_MUL    = 3'd5;
   localparam logic [2:0] S_DIV    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [3:0]         byte_index_ff, byte_index_in;
   logic               in_frame_ff, in_frame_in;
   byte_type           frame_bytes_ff [STORED_BYTES];
   logic               awaiting_ref_ff, awaiting_ref_in;
   word_type           reference_ff, reference_in;
   word_type           prev_raw_ff, prev_raw_in;
   logic [15:0]        turn_ff, turn_in;
   logic [31:0]        prev_unwrapped_ff, prev_unwrapped_in;
   logic [31:0]        prev_time_ff, prev_time_in;
   logic [31:0]        frames_seen_ff, frames_seen_in;
   logic [14:0]        high_ff, high_in;
   logic [15:0]        low_ff, low_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [31:0]        time_ff, time_in;
   logic [31:0]        mul_ff, mul_in;
   logic [31:0]        unwrapped_ff, unwrapped_in;
   logic               neg_ff, neg_in;
   logic [32:0]        mag_ff, mag_in;
   logic [31:0]        dt_ff, dt_in;
   logic [PROD_WIDTH-1:0] acc_ff, acc_in;
   logic [31:0]        rem_ff, rem_in;
   logic [5:0]         step_ff, step_in;
   logic [31:0]        vel_ff, vel_in;
   logic               first_ff, first_in;

   word_type           rsp_raw_angle_ff, rsp_raw_rate_ff;
   word_type           rsp_accel_x_ff, rsp_accel_y_ff, rsp_accel_z_ff;
   logic [31:0]        rsp_unwrapped_ff, rsp_velocity_ff, rsp_frame_count_ff;
   logic               rsp_first_ff, rsp_load;

   logic [3:0]         pos;
   logic [3:0]         store_idx;
   logic               store_en;
   word_type           ang;
   logic               over_new, under_new, over_prev, under_prev;
   logic [32:0]        delta;
   logic [31:0]        dt_calc;
   logic [53:0]        add_a, add_b, add_sum;
   logic               add_sub;
   logic               mul_bit;
   logic               div_ok;
   logic [32:0]        rem_shift;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign pos = in_frame_ff ? byte_index_ff : 4'd0;
   assign store_idx = pos - 4'(FIRST_STORED);
   assign ang = neg_word(frame_bytes_ff[0], frame_bytes_ff[1]);

   assign over_new   = $signed({ang[15], ang}) > $signed({2'b00, high_ff});
   assign under_new  = $signed(ang) < $signed(low_ff);
   assign over_prev  = $signed({prev_raw_ff[15], prev_raw_ff}) > $signed({2'b00, high_ff});
   assign under_prev = $signed(prev_raw_ff) < $signed(low_ff);

   assign delta   = {unwrapped_ff[31], unwrapped_ff} - {prev_unwrapped_ff[31], prev_unwrapped_ff};
   assign dt_calc = time_ff - prev_time_ff;

   assign mul_bit   = VEL_SCALE[5'(MUL_BITS - 1) - step_ff[4:0]];
   assign rem_shift = {rem_ff, acc_ff[PROD_WIDTH-1]};

   // shared adder for the scale and divide loops
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      if (state_ff == S_MUL) begin
         add_a = {1'b0, acc_ff[PROD_WIDTH-2:0], 1'b0};
         add_b = mul_bit ? 54'(mag_ff) : '0;
      end else begin
         add_a   = 54'(rem_shift);
         add_b   = 54'(dt_ff);
         add_sub = 1'b1;
      end
      add_sum = add_a + (add_sub ? ~add_b : add_b) + 54'(add_sub);
   end

   assign div_ok  = !add_sum[53];
   assign store_en = req_valid && req_ready && (pos inside {[FIRST_STORED:LAST_STORED]});

   always_comb begin
      state_in          = state_ff;
      byte_index_in     = byte_index_ff;
      in_frame_in       = in_frame_ff;
      awaiting_ref_in   = awaiting_ref_ff;
      reference_in      = reference_ff;
      prev_raw_in       = prev_raw_ff;
      turn_in           = turn_ff;
      prev_unwrapped_in = prev_unwrapped_ff;
      prev_time_in      = prev_time_ff;
      frames_seen_in    = frames_seen_ff;
      high_in           = high_ff;
      low_in            = low_ff;
      time_in           = time_ff;
      mul_in            = mul_ff;
      unwrapped_in      = unwrapped_ff;
      neg_in            = neg_ff;
      mag_in            = mag_ff;
      dt_in             = dt_ff;
      acc_in            = acc_ff;
      rem_in            = rem_ff;
      step_in           = step_ff;
      vel_in            = vel_ff;
      first_in          = first_ff;
      rsp_load          = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         case (csr_index)
            CSR_WRAP_HIGH: high_in = csr_data[14:0];
            CSR_WRAP_LOW:  low_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && (in_frame_ff || req_rx_byte == HEADER_BYTE)) begin
               if ({1'b0, pos} < LAST_POS) begin
                  byte_index_in = pos + 4'd1;
                  in_frame_in   = 1'b1;
               end else begin
                  byte_index_in = 4'd0;
                  in_frame_in   = 1'b0;
                  time_in       = req_arrival_time_us;
                  state_in      = S_TURN;
               end
            end
         end
         S_TURN: begin
            prev_raw_in = ang;
            if (awaiting_ref_ff) begin
               awaiting_ref_in = 1'b0;
               reference_in    = ang;
               prev_time_in    = time_ff;
               unwrapped_in    = '0;
               vel_in          = '0;
               first_in        = 1'b1;
               state_in        = S_DONE;
            end else begin
               first_in = 1'b0;
               if (over_new && under_prev) begin
                  turn_in = turn_ff - 16'd1;
               end else if (over_prev && under_new) begin
                  turn_in = turn_ff + 16'd1;
               end
               state_in = S_UNWRAP;
            end
         end
         S_UNWRAP: begin
            mul_in   = 32'($signed({{16{turn_ff[15]}}, turn_ff}) * TURN_SPAN);
            state_in = S_DELTA;
         end
         S_DELTA: begin
            unwrapped_in = ({{16{ang[15]}}, ang} - {{16{reference_ff[15]}}, reference_ff})
                           + mul_ff;
            state_in     = S_PREP;
         end
         S_PREP: begin
            neg_in            = delta[32];
            mag_in            = delta[32] ? 33'd0 - delta : delta;
            dt_in             = dt_calc;
            prev_time_in      = time_ff;
            prev_unwrapped_in = unwrapped_ff;
            frames_seen_in    = frames_seen_ff + 32'd1;
            acc_in            = '0;
            step_in           = '0;
            if (dt_calc == 32'd0) begin
               vel_in   = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            acc_in = add_sum[PROD_WIDTH-1:0];
            if (step_ff == 6'(MUL_BITS - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               state_in = S_DIV;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         S_DIV: begin
            rem_in = div_ok ? add_sum[31:0] : rem_shift[31:0];
            acc_in = {acc_ff[PROD_WIDTH-2:0], div_ok};
            if (step_ff == 6'(DIV_STEPS - 1)) begin
               step_in = '0;
               if (neg_ff) begin
                  if ((|acc_in[PROD_WIDTH-1:32]) || (acc_in[31:0] > 32'h8000_0000)) begin
                     vel_in = 32'h8000_0000;
                  end else begin
                     vel_in = 32'd0 - acc_in[31:0];
                  end
               end else begin
                  if (|acc_in[PROD_WIDTH-1:31]) begin
                     vel_in = 32'h7FFF_FFFF;
                  end else begin
                     vel_in = acc_in[31:0];
                  end
               end
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         byte_index_ff     <= '0;
         in_frame_ff       <= 1'b0;
         awaiting_ref_ff   <= 1'b1;
         reference_ff      <= '0;
         prev_raw_ff       <= '0;
         turn_ff           <= '0;
         prev_unwrapped_ff <= '0;
         prev_time_ff      <= '0;
         frames_seen_ff    <= '0;
         high_ff           <= 15'd9000;
         low_ff            <= 16'hDCD8;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         byte_index_ff     <= byte_index_in;
         in_frame_ff       <= in_frame_in;
         awaiting_ref_ff   <= awaiting_ref_in;
         reference_ff      <= reference_in;
         prev_raw_ff       <= prev_raw_in;
         turn_ff           <= turn_in;
         prev_unwrapped_ff <= prev_unwrapped_in;
         prev_time_ff      <= prev_time_in;
         frames_seen_ff    <= frames_seen_in;
         high_ff           <= high_in;
         low_ff            <= low_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         frame_bytes_ff[store_idx] <= req_rx_byte;
      end
      time_ff      <= time_in;
      mul_ff       <= mul_in;
      unwrapped_ff <= unwrapped_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      dt_ff        <= dt_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      vel_ff       <= vel_in;
      first_ff     <= first_in;
      if (rsp_load) begin
         rsp_raw_angle_ff   <= ang;
         rsp_raw_rate_ff    <= neg_word(frame_bytes_ff[2], frame_bytes_ff[3]);
         rsp_accel_x_ff     <= neg_word(frame_bytes_ff[4], frame_bytes_ff[5]);
         rsp_accel_y_ff     <= neg_word(frame_bytes_ff[6], frame_bytes_ff[7]);
         rsp_accel_z_ff     <= neg_word(frame_bytes_ff[8], frame_bytes_ff[9]);
         rsp_unwrapped_ff   <= unwrapped_ff;
         rsp_velocity_ff    <= vel_ff;
         rsp_first_ff       <= first_ff;
         rsp_frame_count_ff <= frames_seen_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_raw_angle        = rsp_raw_angle_ff;
   assign rsp_raw_rate         = rsp_raw_rate_ff;
   assign rsp_accel_x          = rsp_accel_x_ff;
   assign rsp_accel_y          = rsp_accel_y_ff;
   assign rsp_accel_z          = rsp_accel_z_ff;
   assign rsp_unwrapped_angle  = $signed(rsp_unwrapped_ff);
   assign rsp_angular_velocity = $signed(rsp_velocity_ff);
   assign rsp_first_frame      = rsp_first_ff;
   assign rsp_frame_count      = rsp_frame_count_ff;

`ifndef NO_ASSERTIONS
   a_first_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_first_frame) |->
      (rsp_unwrapped_angle == 32'sd0 && rsp_angular_velocity == 32'sd0))
      else $error("first frame result carries nonzero angle or velocity");

   a_frame_end_starts_seq: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && in_frame_ff && {1'b0, byte_index_ff} == LAST_POS)
      |=> (state_ff == S_TURN))
      else $error("last byte of a frame did not start the sequencer");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_DIV) |-> (dt_ff != 32'd0))
      else $error("scale or divide loop running with zero elapsed time");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < dt_ff))
      else $error("division remainder not below divisor");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid && !rsp_ready) |=> (state_ff == S_DONE))
      else $error("sequencer left its last step while result register full");
`endif

endmodule

// ===== dv/gyro_frame_checker.sv =====
// Frame result predictor and comparator for the gyro frame parser testbench.
module gyro_frame_checker
   import gfpu_pkg::*;
#(
   parameter int FRAME_LENGTH = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic [31:0]        req_arrival_time_us,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_raw_angle,
   input  logic signed [15:0] rsp_raw_rate,
   input  logic signed [15:0] rsp_accel_x,
   input  logic signed [15:0] rsp_accel_y,
   input  logic signed [15:0] rsp_accel_z,
   input  logic signed [31:0] rsp_unwrapped_angle,
   input  logic signed [31:0] rsp_angular_velocity,
   input  logic               rsp_first_frame,
   input  logic [31:0]        rsp_frame_count,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 error_count,
   output int                 pending
);

   localparam longint VEL_MAX = 64'sd2147483647;
   localparam longint VEL_MIN = -64'sd2147483648;

   typedef struct packed {
      word_type           raw_angle;
      word_type           raw_rate;
      word_type           accel_x;
      word_type           accel_y;
      word_type           accel_z;
      logic signed [31:0] unwrapped_angle;
      logic signed [31:0] angular_velocity;
      logic               first_frame;
      logic [31:0]        frame_count;
   } frame_result_type;

   frame_result_type   expected_frames[$];
   frame_result_type   oldest;
   logic [14:0]        high_threshold;
   logic signed [15:0] low_threshold;
   logic               in_frame;
   logic [3:0]         byte_pos;
   byte_type           frame_store [STORED_BYTES];
   logic               awaiting_ref;
   word_type           ref_angle;
   word_type           last_angle;
   logic signed [15:0] turns;
   logic signed [31:0] last_unwrapped;
   logic [31:0]        last_stamp;
   logic [31:0]        frames_after_first;
   int                 failures = 0;

   assign error_count = failures;

   task report_failure(input string msg);
      failures++;
      $display("checker: %0t %s", $time, msg);
   endtask

   task compare_field(input string what, input longint got, input longint want);
      if (got != want)
         report_failure($sformatf("%s is %0d, expected %0d", what, got, want));
   endtask

   task absorb_byte(input byte_type value, input logic [31:0] stamp);
      logic [3:0]         pos;
      word_type           words [5];
      word_type           ang;
      logic signed [31:0] unwrapped;
      logic signed [31:0] velocity;
      logic [31:0]        elapsed;
      longint             delta;
      longint             quotient;
      frame_result_type   res;
      pos = in_frame ? byte_pos : 4'd0;
      if (pos >= FIRST_STORED && pos <= LAST_STORED)
         frame_store[pos - FIRST_STORED] = value;
      if (in_frame || value == HEADER_BYTE) begin
         in_frame = 1'b1;
         if (pos + 1 < FRAME_LENGTH) begin
            byte_pos = 4'(pos + 1);
         end else begin
            byte_pos = 4'd0;
            in_frame = 1'b0;
            for (int k = 0; k < 5; k++)
               words[k] = 16'd0 - {frame_store[2 * k + 1], frame_store[2 * k]};
            ang = words[0];
            velocity = 32'sd0;
            if (awaiting_ref) begin
               awaiting_ref = 1'b0;
               ref_angle = ang;
               last_angle = ang;
               last_stamp = stamp;
               unwrapped = 32'sd0;
               res.first_frame = 1'b1;
            end else begin
               if (int'(ang) > int'(high_threshold) && last_angle < low_threshold)
                  turns = turns - 16'sd1;
               else if (int'(last_angle) > int'(high_threshold) && ang < low_threshold)
                  turns = turns + 16'sd1;
               last_angle = ang;
               unwrapped = int'(ang) - int'(ref_angle) + int'(turns) * 36000;
               delta = longint'(unwrapped) - longint'(last_unwrapped);
               elapsed = stamp - last_stamp;
               if (elapsed != 32'd0) begin
                  quotient = (delta * 1000000) / longint'({32'd0, elapsed});
                  if (quotient > VEL_MAX)
                     quotient = VEL_MAX;
                  else if (quotient < VEL_MIN)
                     quotient = VEL_MIN;
                  velocity = 32'(quotient);
               end
               last_stamp = stamp;
               last_unwrapped = unwrapped;
               frames_after_first = frames_after_first + 32'd1;
               res.first_frame = 1'b0;
            end
            res.raw_angle = words[0];
            res.raw_rate = words[1];
            res.accel_x = words[2];
            res.accel_y = words[3];
            res.accel_z = words[4];
            res.unwrapped_angle = unwrapped;
            res.angular_velocity = velocity;
            res.frame_count = frames_after_first;
            expected_frames.push_back(res);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_frames.delete();
         high_threshold = 15'd9000;
         low_threshold = -16'sd9000;
         in_frame = 1'b0;
         byte_pos = 4'd0;
         foreach (frame_store[i])
            frame_store[i] = 8'd0;
         awaiting_ref = 1'b1;
         ref_angle = 16'sd0;
         last_angle = 16'sd0;
         turns = 16'sd0;
         last_unwrapped = 32'sd0;
         last_stamp = 32'd0;
         frames_after_first = 32'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WRAP_HIGH: high_threshold = csr_data[14:0];
               CSR_WRAP_LOW: low_threshold = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               report_failure($sformatf("result with nothing expected, frame_count %0d",
                                        rsp_frame_count));
            end else begin
               oldest = expected_frames.pop_front();
               compare_field("raw_angle", longint'(rsp_raw_angle),
                             longint'(oldest.raw_angle));
               compare_field("raw_rate", longint'(rsp_raw_rate),
                             longint'(oldest.raw_rate));
               compare_field("accel_x", longint'(rsp_accel_x), longint'(oldest.accel_x));
               compare_field("accel_y", longint'(rsp_accel_y), longint'(oldest.accel_y));
               compare_field("accel_z", longint'(rsp_accel_z), longint'(oldest.accel_z));
               compare_field("unwrapped_angle", longint'(rsp_unwrapped_angle),
                             longint'(oldest.unwrapped_angle));
               compare_field("angular_velocity", longint'(rsp_angular_velocity),
                             longint'(oldest.angular_velocity));
               compare_field("first_frame", longint'(rsp_first_frame),
                             longint'(oldest.first_frame));
               compare_field("frame_count", longint'(rsp_frame_count),
                             longint'(oldest.frame_count));
            end
         end
         if (req_valid && req_ready)
            absorb_byte(req_rx_byte, req_arrival_time_us);
      end
      pending <= expected_frames.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the gyro frame parser testbench: clock, reset, byte stimulus and verdict.
module testbench;
   import gfpu_pkg::*;

   localparam int FRAME_LENGTH = 15;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 100;
   localparam int FRAMES_PER_PHASE = 9;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'd0;
   logic [31:0]        req_arrival_time_us = 32'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_raw_angle;
   logic signed [15:0] rsp_raw_rate;
   logic signed [15:0] rsp_accel_x;
   logic signed [15:0] rsp_accel_y;
   logic signed [15:0] rsp_accel_z;
   logic signed [31:0] rsp_unwrapped_angle;
   logic signed [31:0] rsp_angular_velocity;
   logic               rsp_first_frame;
   logic [31:0]        rsp_frame_count;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_WRAP_HIGH;
   logic [15:0]        csr_data = 16'd0;

   int          errors;
   int          pending;
   int          idle_cycles = 0;
   int          hold_left = 0;
   bit          quiet = 1'b0;
   logic [31:0] now_us = 32'd0;
   logic [31:0] last_end_us = 32'd0;

   gyro_frame_parser_unwrap_core #(.FRAME_LENGTH(FRAME_LENGTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_rx_byte(req_rx_byte), .req_arrival_time_us(req_arrival_time_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_raw_angle(rsp_raw_angle), .rsp_raw_rate(rsp_raw_rate),
      .rsp_accel_x(rsp_accel_x), .rsp_accel_y(rsp_accel_y), .rsp_accel_z(rsp_accel_z),
      .rsp_unwrapped_angle(rsp_unwrapped_angle),
      .rsp_angular_velocity(rsp_angular_velocity),
      .rsp_first_frame(rsp_first_frame), .rsp_frame_count(rsp_frame_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   gyro_frame_checker #(.FRAME_LENGTH(FRAME_LENGTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_rx_byte(req_rx_byte), .req_arrival_time_us(req_arrival_time_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_raw_angle(rsp_raw_angle), .rsp_raw_rate(rsp_raw_rate),
      .rsp_accel_x(rsp_accel_x), .rsp_accel_y(rsp_accel_y), .rsp_accel_z(rsp_accel_z),
      .rsp_unwrapped_angle(rsp_unwrapped_angle),
      .rsp_angular_velocity(rsp_angular_velocity),
      .rsp_first_frame(rsp_first_frame), .rsp_frame_count(rsp_frame_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .error_count(errors), .pending(pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         hold_left <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   function automatic logic [31:0] next_stamp();
      if ($urandom_range(0, 39) == 0)
         now_us = $urandom;
      else
         now_us = now_us + $urandom_range(0, 500);
      return now_us;
   endfunction

   task send_byte(input byte_type value, input logic [31:0] stamp);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      req_arrival_time_us <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // fields: {accel_z, accel_y, accel_x, rate, angle} as the block reports them
   task send_frame(input logic [4:0][15:0] fields, input int end_gap);
      byte_type    value;
      logic [31:0] stamp;
      logic [15:0] coded;
      for (int i = 0; i < FRAME_LENGTH; i++) begin
         stamp = next_stamp();
         if (i == 0) begin
            value = HEADER_BYTE;
         end else if (i >= FIRST_STORED && i <= LAST_STORED) begin
            coded = 16'd0 - fields[(i - FIRST_STORED) / 2];
            value = ((i - FIRST_STORED) % 2 == 0) ? coded[7:0] : coded[15:8];
         end else begin
            value = byte_type'($urandom_range(0, 255));
         end
         if (i == FRAME_LENGTH - 1) begin
            if (end_gap >= 0)
               stamp = last_end_us + end_gap;
            last_end_us = stamp;
         end
         send_byte(value, stamp);
      end
   endtask

   task set_thresholds(input logic [14:0] high, input logic signed [15:0] low);
      csr_valid <= 1'b1;
      csr_index <= CSR_WRAP_HIGH;
      csr_data <= {1'b0, high};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_WRAP_LOW;
      csr_data <= low;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [15:0]        angle;
      logic [4:0][15:0]   fields;
      logic [14:0]        high;
      logic signed [15:0] low;
      int                 end_gap;
      int                 pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle junk, then reference, zero-elapsed turn, saturating jump
      send_byte(8'h00, next_stamp());
      send_byte(8'hFF, next_stamp());
      send_byte(8'h55, next_stamp());
      send_frame({16'h7FFF, 16'hFFFF, 16'h0000, 16'h8000, 16'd17999}, -1);
      send_frame({16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, -16'sd17999}, 0);
      send_frame({16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'd5000}, 1);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               high = 15'd18000;
               low = -16'sd18000;
            end
            1: begin
               high = 15'd0;
               low = 16'sd0;
            end
            2: begin
               high = 15'($urandom_range(0, 18000));
               low = 16'(-int'($urandom_range(0, 18000)));
            end
            default: begin
               quiet = 1'b1;
               high = 15'd9000;
               low = -16'sd9000;
            end
         endcase
         set_thresholds(high, low);
         for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, 4))
                  send_byte(($urandom_range(0, 9) == 0) ? HEADER_BYTE :
                            byte_type'($urandom_range(0, 255)), next_stamp());
            end
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               angle = 16'($urandom_range(0, 36000) - 18000);
            end else if (pick < 7) begin
               angle = 16'($urandom_range(17000, 18000));
               if ($urandom_range(0, 1) == 1)
                  angle = 16'd0 - angle;
            end else if (pick < 9) begin
               angle = 16'($urandom);
            end else begin
               angle = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
            end
            fields = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), angle};
            pick = $urandom_range(0, 7);
            if (pick == 0)
               end_gap = 0;
            else if (pick == 1)
               end_gap = $urandom_range(1, 3);
            else
               end_gap = -1;
            send_frame(fields, end_gap);
         end
         wait_drained();
      end

      if (errors == 0 && pending == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ===== gyro_frame_parser_unwrap_core.f =====
design/gfpu_pkg.sv
design/gyro_frame_parser_unwrap_core.sv
dv/gyro_frame_checker.sv
dv/testbench.sv
